// ===== rtl/dmd_pkg.sv =====
// Package: types and constants for the dial motion detector.
package dmd_pkg;

    localparam int POS_BITS_DEF = 16;
    localparam int POS_W        = 16;
    localparam int TRAVEL_W     = 16;
    localparam int CNT_W        = 16;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_STOP_TIMEOUT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_TIMEOUT = 2'd1;

    localparam logic [CNT_W-1:0] STOP_TIMEOUT_RST   = 16'd100;
    localparam logic [CNT_W-1:0] SAMPLE_TIMEOUT_RST = 16'd10;

    typedef enum logic [1:0] {
        MODE_STOPPED  = 2'd0,
        MODE_FORWARD  = 2'd1,
        MODE_BACKWARD = 2'd2,
        MODE_WAIT     = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        EV_NONE     = 2'd0,
        EV_STOPPED  = 2'd1,
        EV_FORWARD  = 2'd2,
        EV_BACKWARD = 2'd3
    } t_event;

endpackage

// ===== rtl/dial_motion_detector.sv =====
// Top level: dial motion detector with input register and result register.
//
//  channel   direction  handshake            payload
//  sample    in         i_valid / o_ready    i_sample_position
//  result    out        o_valid / i_ready    o_event_res, o_motion_state, o_net_travel
//  config    in         i_cfg_we             i_cfg_idx, i_cfg_data
//
//  One transaction per cycle sustained while the result side is ready; each sample passes
//  through the input register, then the state update into the result register.
//  Synchronous active-low reset: mode stopped, position, travel and counters zero,
//  timeouts 100 and 10.
//  A stalled result holds both stages; the input stage takes a new sample
//  whenever it is empty or the result stage is free or drains in the same cycle.
module dial_motion_detector #(
    parameter int POS_BITS = dmd_pkg::POS_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic [dmd_pkg::POS_W-1:0]        i_sample_position,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [1:0]                       o_event_res,
    output logic [1:0]                       o_motion_state,
    output logic [dmd_pkg::TRAVEL_W-1:0]     o_net_travel,
    input  logic                             i_cfg_we,
    input  logic [dmd_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [dmd_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import dmd_pkg::*;

    localparam int PW = (POS_BITS < POS_W) ? POS_BITS : POS_W;
    localparam int SW = POS_BITS + 1;

    logic [CNT_W-1:0]    r_stop_timeout;
    logic [CNT_W-1:0]    r_sample_timeout;

    logic                r_in_vld;
    logic [PW-1:0]       r_pos;

    t_mode               r_mode, n_mode;
    logic [PW-1:0]       r_last;
    logic [TRAVEL_W-1:0] r_travel, n_travel;
    logic [CNT_W-1:0]    r_stop_cnt, n_stop_cnt;
    logic [CNT_W-1:0]    r_samp_cnt, n_samp_cnt;

    logic                r_out_vld;
    t_event              r_event, n_event;

    logic                out_free;
    logic                adv;
    logic                same;
    logic                gt;
    logic [PW-1:0]       diff;
    logic [SW-1:0]       wrap_sum;
    logic                fwd;
    logic [TRAVEL_W-1:0] d16;
    logic [TRAVEL_W:0]   add_sum;
    logic [CNT_W-1:0]    stop_dec;
    logic [CNT_W-1:0]    samp_dec;
    logic                dir_fwd;

    assign out_free = !r_out_vld || i_ready;
    assign adv      = r_in_vld && out_free;
    assign o_ready  = !r_in_vld || out_free;

    assign same     = (r_pos == r_last);
    assign gt       = (r_pos > r_last);
    assign diff     = gt ? (r_pos - r_last) : (r_last - r_pos);
    assign wrap_sum = SW'(r_last) + SW'(diff);
    assign fwd      = gt || wrap_sum[POS_BITS];
    assign d16      = TRAVEL_W'(diff);
    assign add_sum  = {1'b0, r_travel} + {1'b0, d16};
    assign stop_dec = (r_stop_cnt == '0) ? '0 : r_stop_cnt - 1'b1;
    assign samp_dec = (r_samp_cnt == '0) ? '0 : r_samp_cnt - 1'b1;
    assign dir_fwd  = (r_mode == MODE_FORWARD);

    always_comb begin
        n_mode     = r_mode;
        n_travel   = r_travel;
        n_stop_cnt = r_stop_cnt;
        n_samp_cnt = r_samp_cnt;
        n_event    = EV_NONE;
        case (r_mode)
            MODE_STOPPED, MODE_WAIT: begin
                if (r_mode == MODE_WAIT) begin
                    n_stop_cnt = stop_dec;
                end
                if (!same) begin
                    n_travel   = d16;
                    n_stop_cnt = r_stop_timeout;
                    n_samp_cnt = r_sample_timeout;
                    n_mode     = fwd ? MODE_FORWARD : MODE_BACKWARD;
                    n_event    = fwd ? EV_FORWARD : EV_BACKWARD;
                end else if (r_mode == MODE_WAIT && stop_dec == '0) begin
                    n_mode  = MODE_STOPPED;
                    n_event = EV_STOPPED;
                end
            end
            MODE_FORWARD, MODE_BACKWARD: begin
                n_stop_cnt = stop_dec;
                n_samp_cnt = samp_dec;
                if (same) begin
                    if (stop_dec == '0) begin
                        n_mode  = MODE_STOPPED;
                        n_event = EV_STOPPED;
                    end else if (samp_dec == '0) begin
                        n_mode = MODE_WAIT;
                    end
                end else begin
                    n_stop_cnt = r_stop_timeout;
                    n_samp_cnt = r_sample_timeout;
                    if (fwd == dir_fwd) begin
                        if (!add_sum[TRAVEL_W]) begin
                            n_travel = add_sum[TRAVEL_W-1:0];
                        end
                        n_event = dir_fwd ? EV_FORWARD : EV_BACKWARD;
                    end else if (d16 > r_travel) begin
                        n_travel = d16 - r_travel;
                        n_mode   = dir_fwd ? MODE_BACKWARD : MODE_FORWARD;
                        n_event  = dir_fwd ? EV_BACKWARD : EV_FORWARD;
                    end else begin
                        n_travel = r_travel - d16;
                        n_event  = dir_fwd ? EV_BACKWARD : EV_FORWARD;
                    end
                end
            end
            default: begin
                n_mode = MODE_STOPPED;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stop_timeout   <= STOP_TIMEOUT_RST;
            r_sample_timeout <= SAMPLE_TIMEOUT_RST;
            r_in_vld         <= 1'b0;
            r_out_vld        <= 1'b0;
            r_mode           <= MODE_STOPPED;
            r_last           <= '0;
            r_travel         <= '0;
            r_stop_cnt       <= '0;
            r_samp_cnt       <= '0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_STOP_TIMEOUT) begin
                    r_stop_timeout <= i_cfg_data;
                end else if (i_cfg_idx == CFG_SAMPLE_TIMEOUT) begin
                    r_sample_timeout <= i_cfg_data;
                end
            end
            if (o_ready) begin
                r_in_vld <= i_valid;
            end
            if (out_free) begin
                r_out_vld <= r_in_vld;
            end
            if (adv) begin
                r_mode     <= n_mode;
                r_last     <= r_pos;
                r_travel   <= n_travel;
                r_stop_cnt <= n_stop_cnt;
                r_samp_cnt <= n_samp_cnt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_pos <= i_sample_position[PW-1:0];
        end
        if (adv) begin
            r_event <= n_event;
        end
    end

    assign o_valid        = r_out_vld;
    assign o_event_res    = r_event;
    assign o_motion_state = r_mode;
    assign o_net_travel   = r_travel;

    // stopped event only lands in the stopped state
    a_stop_ev: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_event == EV_STOPPED) |-> (r_mode == MODE_STOPPED))
        else $error("stopped event outside stopped state");

    // stopped or wait state never reports a movement event
    a_idle_ev: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && (r_mode == MODE_STOPPED || r_mode == MODE_WAIT))
        |-> (r_event == EV_NONE || r_event == EV_STOPPED))
        else $error("movement event in idle state");

    // held input sample is not overwritten
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && !out_free) |=> (r_in_vld && $stable(r_pos)))
        else $error("input register lost a transaction");

    // state moves only when a transaction advances
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!adv && $past(i_rst_n)) |=> ($stable(r_mode) && $stable(r_travel)))
        else $error("state changed without a transaction");

endmodule

// ===== test/tb_dial_motion_detector.sv =====
// Testbench for dial_motion_detector: table-driven directed ticks, random phases, checker.
`timescale 1ns / 100ps

module tb_dial_motion_detector;
    import dmd_pkg::*;

    localparam int CYCLE_LIMIT = 100000;
    localparam int N_PHASES = 5;
    localparam int PHASE_TICKS = 80;
    localparam int N_ROWS = 30;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

    typedef struct packed {
        t_event              ev;
        t_mode               st;
        logic [TRAVEL_W-1:0] net;
    } t_motion_result;

    typedef enum logic {ROW_SAMPLE, ROW_WRITE} t_row_kind;

    typedef struct packed {
        t_row_kind             kind;
        logic [CFG_IDX_W-1:0]  idx;
        logic [POS_W-1:0]      val;
        logic                  chk;
        t_event                ev;
        t_mode                 st;
        logic [TRAVEL_W-1:0]   net;
    } t_dir_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_valid = 1'b0;
    logic                  o_ready;
    logic [POS_W-1:0]      i_sample_position = '0;
    logic                  o_valid;
    logic                  i_ready = 1'b0;
    logic [1:0]            o_event_res;
    logic [1:0]            o_motion_state;
    logic [TRAVEL_W-1:0]   o_net_travel;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    // tracked dial state
    t_mode               trk_mode = MODE_STOPPED;
    logic [POS_W-1:0]    pos_last = '0;
    logic [TRAVEL_W-1:0] travel = '0;
    logic [CNT_W-1:0]    stop_cnt = '0;
    logic [CNT_W-1:0]    sample_cnt = '0;
    logic [CNT_W-1:0]    stop_limit = STOP_TIMEOUT_RST;
    logic [CNT_W-1:0]    sample_limit = SAMPLE_TIMEOUT_RST;

    t_motion_result pending_motion[$];
    int n_fed = 0;
    int n_seen = 0;
    int n_mismatch = 0;
    int cycles = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;

    t_dir_row dir_rows [N_ROWS] = '{
        '{ROW_SAMPLE, CFG_STOP_TIMEOUT,   16'h0000, 1'b1, EV_NONE,    MODE_STOPPED, 16'h0000},
        '{ROW_SAMPLE, CFG_STOP_TIMEOUT,   16'hFFFF, 1'b1, EV_FORWARD, MODE_FORWARD, 16'hFFFF},
        '{ROW_SAMPLE, CFG_STOP_TIMEOUT,   16'h0000, 1'b0, EV_NONE,    MODE_STOPPED, 16'h0000},
        '{ROW_SAMPLE, CFG_STOP_TIMEOUT,   16'h8000, 1'b0, EV_NONE,    MODE_STOPPED, 16'h0000},
        '{ROW_SAMPLE, CFG_STOP_TIMEOUT,   16'h7000, 1'b0, EV_NONE,    MODE_STOPPED, 16'h0000},
        '{ROW_WRITE,  CFG_STOP_TIMEOUT,   16'h0003, 1'b0, EV_NONE,    MODE_STOPPED, 16'h0000},
        '{ROW_WRITE,  CFG_SAMPLE_TIMEOUT, 16'h0002, 1'b0, EV_NONE,    MODE_STOPPED, 16'h0000},
        '{ROW_SAMPLE, CFG_STOP_TIMEOUT,   16'h7010, 1'b0, EV_NONE,    MODE_STOPPED, 16'h0000},
        '{ROW_SAMPLE, CFG_STOP_TIMEOUT,   16'h7010, 1'b0, EV_NONE,    MODE_STOPPED, 16'h0000},
        '{ROW_SAMPLE, CFG_STOP_TIMEOUT,   16'h7010, 1'b0, EV_NONE,    MODE_STOPPED, 16'h0000},
        '{ROW_SAMPLE, CFG_STOP_TIMEOUT,   16'h7010, 1'b0, EV_NONE,    MODE_STOPPED, 16'h0000},
        '{ROW_SAMPLE, CFG_STOP_TIMEOUT,   16'h7010, 1'b0, EV_NONE,    MODE_STOPPED, 16'h0000},
        '{ROW_SAMPLE, CFG_STOP_TIMEOUT,   16'h7000, 1'b0, EV_NONE,    MODE_STOPPED, 16'h0000},
        '{ROW_SAMPLE, CFG_STOP_TIMEOUT,   16'h7008, 1'b0, EV_NONE,    MODE_STOPPED, 16'h0000},
        '{ROW_SAMPLE, CFG_STOP_TIMEOUT,   16'h7018, 1'b0, EV_NONE,    MODE_STOPPED, 16'h0000},
        '{ROW_SAMPLE, CFG_STOP_TIMEOUT,   16'h7018, 1'b0, EV_NONE,    MODE_STOPPED, 16'h0000},
        '{ROW_SAMPLE, CFG_STOP_TIMEOUT,   16'h7000, 1'b0, EV_NONE,    MODE_STOPPED, 16'h0000},
        '{ROW_SAMPLE, CFG_STOP_TIMEOUT,   16'h7000, 1'b0, EV_NONE,    MODE_STOPPED, 16'h0000},
        '{ROW_SAMPLE, CFG_STOP_TIMEOUT,   16'h7000, 1'b0, EV_NONE,    MODE_STOPPED, 16'h0000},
        '{ROW_SAMPLE, CFG_STOP_TIMEOUT,   16'h6FF0, 1'b0, EV_NONE,    MODE_STOPPED, 16'h0000},
        '{ROW_WRITE,  CFG_STOP_TIMEOUT,   16'h0000, 1'b0, EV_NONE,    MODE_STOPPED, 16'h0000},
        '{ROW_WRITE,  CFG_SAMPLE_TIMEOUT, 16'h0000, 1'b0, EV_NONE,    MODE_STOPPED, 16'h0000},
        '{ROW_WRITE,  CFG_SPARE_2,        16'hFFFF, 1'b0, EV_NONE,    MODE_STOPPED, 16'h0000},
        '{ROW_WRITE,  CFG_SPARE_3,        16'hFFFF, 1'b0, EV_NONE,    MODE_STOPPED, 16'h0000},
        '{ROW_SAMPLE, CFG_STOP_TIMEOUT,   16'h6FF1, 1'b0, EV_NONE,    MODE_STOPPED, 16'h0000},
        '{ROW_SAMPLE, CFG_STOP_TIMEOUT,   16'h6FF1, 1'b0, EV_NONE,    MODE_STOPPED, 16'h0000},
        '{ROW_WRITE,  CFG_STOP_TIMEOUT,   16'hFFFF, 1'b0, EV_NONE,    MODE_STOPPED, 16'h0000},
        '{ROW_WRITE,  CFG_SAMPLE_TIMEOUT, 16'hFFFF, 1'b0, EV_NONE,    MODE_STOPPED, 16'h0000},
        '{ROW_SAMPLE, CFG_STOP_TIMEOUT,   16'h0000, 1'b0, EV_NONE,    MODE_STOPPED, 16'h0000},
        '{ROW_SAMPLE, CFG_STOP_TIMEOUT,   16'hFFFF, 1'b0, EV_NONE,    MODE_STOPPED, 16'h0000}
    };

    dial_motion_detector dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_sample_position (i_sample_position),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_event_res       (o_event_res),
        .o_motion_state    (o_motion_state),
        .o_net_travel      (o_net_travel),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    function automatic logic [CNT_W-1:0] count_down(input logic [CNT_W-1:0] v);
        return (v != '0) ? v - 1'b1 : '0;
    endfunction

    // one tick of the dial tracker; updates tracked state
    function automatic t_motion_result advance_dial(input logic [POS_W-1:0] pos);
        logic [POS_W-1:0]  d;
        logic [POS_W:0]    sum;
        logic              same;
        logic              fwd;
        logic              dir_fwd;
        t_event            ev;
        t_motion_result    r;
        ev = EV_NONE;
        same = (pos == pos_last);
        fwd = 1'b0;
        d = '0;
        if (!same) begin
            d = (pos > pos_last) ? pos - pos_last : pos_last - pos;
            sum = {1'b0, pos_last} + {1'b0, d};
            fwd = (pos > pos_last) || sum[POS_W];
            pos_last = pos;
        end
        case (trk_mode)
            MODE_STOPPED: begin
                if (!same) begin
                    travel = d;
                    stop_cnt = stop_limit;
                    sample_cnt = sample_limit;
                    trk_mode = fwd ? MODE_FORWARD : MODE_BACKWARD;
                    ev = fwd ? EV_FORWARD : EV_BACKWARD;
                end
            end
            MODE_WAIT: begin
                stop_cnt = count_down(stop_cnt);
                if (same) begin
                    if (stop_cnt == '0) begin
                        trk_mode = MODE_STOPPED;
                        ev = EV_STOPPED;
                    end
                end else begin
                    travel = d;
                    stop_cnt = stop_limit;
                    sample_cnt = sample_limit;
                    trk_mode = fwd ? MODE_FORWARD : MODE_BACKWARD;
                    ev = fwd ? EV_FORWARD : EV_BACKWARD;
                end
            end
            default: begin
                dir_fwd = (trk_mode == MODE_FORWARD);
                stop_cnt = count_down(stop_cnt);
                sample_cnt = count_down(sample_cnt);
                if (same) begin
                    if (stop_cnt == '0) begin
                        trk_mode = MODE_STOPPED;
                        ev = EV_STOPPED;
                    end else if (sample_cnt == '0) begin
                        trk_mode = MODE_WAIT;
                    end
                end else begin
                    stop_cnt = stop_limit;
                    sample_cnt = sample_limit;
                    if (fwd == dir_fwd) begin
                        sum = {1'b0, travel} + {1'b0, d};
                        if (!sum[TRAVEL_W])
                            travel = sum[TRAVEL_W-1:0];
                        ev = dir_fwd ? EV_FORWARD : EV_BACKWARD;
                    end else if (d > travel) begin
                        travel = d - travel;
                        trk_mode = dir_fwd ? MODE_BACKWARD : MODE_FORWARD;
                        ev = dir_fwd ? EV_BACKWARD : EV_FORWARD;
                    end else begin
                        travel = travel - d;
                        ev = dir_fwd ? EV_BACKWARD : EV_FORWARD;
                    end
                end
            end
        endcase
        r.ev = ev;
        r.st = trk_mode;
        r.net = travel;
        return r;
    endfunction

    task automatic send_sample(input logic [POS_W-1:0] pos, input logic use_typed,
                               input t_motion_result typed);
        t_motion_result r;
        i_valid <= 1'b1;
        i_sample_position <= pos;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        r = advance_dial(pos);
        pending_motion.push_back(use_typed ? typed : r);
        n_fed++;
        if (!(n_fed >= 200 && n_fed < 300) && $urandom_range(99) < 7) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    // sender pause until the block has delivered everything
    task automatic drain;
        i_valid <= 1'b0;
        while (pending_motion.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        if (idx == CFG_STOP_TIMEOUT)
            stop_limit = val;
        else if (idx == CFG_SAMPLE_TIMEOUT)
            sample_limit = val;
    endtask

    // result checker and receiver back-pressure
    always @(posedge i_clk) begin
        t_motion_result e;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_motion.size() == 0) begin
                $display("%0t: unexpected transaction ev=%0d st=%0d net=%0h",
                         $time, o_event_res, o_motion_state, o_net_travel);
                n_mismatch++;
            end else begin
                e = pending_motion.pop_front();
                if (o_event_res !== e.ev) begin
                    $display("%0t: event expected %0d actual %0d", $time, e.ev, o_event_res);
                    n_mismatch++;
                end
                if (o_motion_state !== e.st) begin
                    $display("%0t: state expected %0d actual %0d", $time, e.st, o_motion_state);
                    n_mismatch++;
                end
                if (o_net_travel !== e.net) begin
                    $display("%0t: net travel expected %0h actual %0h",
                             $time, e.net, o_net_travel);
                    n_mismatch++;
                end
            end
            n_seen++;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_ready <= 1'b0;
        end else if (!hold_done && n_seen >= 120) begin
            hold_done = 1'b1;
            hold_left = 60;
            i_ready <= 1'b0;
        end else begin
            i_ready <= (n_seen >= 200 && n_seen < 300) || ($urandom_range(99) >= 7);
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        int                  burst_left;
        int                  sel;
        logic [POS_W-1:0]    pos;
        logic [POS_W-1:0]    step;
        logic [CNT_W-1:0]    s_to;
        logic [CNT_W-1:0]    w_to;
        t_motion_result      typed;
        burst_left = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < N_ROWS; r++) begin
            if (dir_rows[r].kind == ROW_WRITE) begin
                drain();
                write_reg(dir_rows[r].idx, dir_rows[r].val);
            end else begin
                i_cfg_we <= 1'b0;
                typed.ev = dir_rows[r].ev;
                typed.st = dir_rows[r].st;
                typed.net = dir_rows[r].net;
                send_sample(dir_rows[r].val, dir_rows[r].chk, typed);
            end
        end

        for (int ph = 0; ph < N_PHASES; ph++) begin
            drain();
            case (ph)
                0: begin s_to = 16'd12;    w_to = 16'd4;    end
                1: begin s_to = 16'd1;     w_to = 16'd1;    end
                2: begin s_to = 16'd100;   w_to = 16'd10;   end
                3: begin s_to = 16'd3;     w_to = 16'd7;    end
                default: begin s_to = 16'hFFFF; w_to = 16'hFFFF; end
            endcase
            write_reg(CFG_STOP_TIMEOUT, s_to);
            write_reg(CFG_SAMPLE_TIMEOUT, w_to);
            i_cfg_we <= 1'b0;
            for (int k = 0; k < PHASE_TICKS; k++) begin
                if (burst_left > 0) begin
                    burst_left--;
                    pos = pos_last;
                end else begin
                    sel = $urandom_range(99);
                    if (sel < 8) begin
                        burst_left = $urandom_range(1, 25);
                        pos = pos_last;
                    end else if (sel < 30) begin
                        pos = pos_last;
                    end else if (sel < 70) begin
                        step = POS_W'($urandom_range(1, 40));
                        pos = $urandom_range(1) ? pos_last + step : pos_last - step;
                    end else if (sel < 85) begin
                        // hover around the wrap point
                        pos = $urandom_range(1) ? 16'hFFFF - POS_W'($urandom_range(15))
                                                : POS_W'($urandom_range(15));
                    end else begin
                        pos = POS_W'($urandom);
                    end
                end
                send_sample(pos, 1'b0, typed);
            end
        end

        i_valid <= 1'b0;
        while (pending_motion.size() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
        if (n_mismatch == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/dmd_pkg.sv
rtl/dial_motion_detector.sv
test/tb_dial_motion_detector.sv
